// ----- design/bsb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types, constants and codes for the B-spline basis evaluator.
// ----------------------------------------------------------------------------
package bsb_pkg;

  localparam int MaxKnots  = 16;
  localparam int MaxDegree = 7;
  localparam int ExtSize   = 2 * (MaxDegree + 1) + MaxKnots;
  localparam int ExtW      = $clog2(ExtSize + 1);
  localparam int KnotW     = $clog2(MaxKnots);
  localparam int DegW      = 3;
  localparam int CntW      = 5;
  localparam int DistW     = 34;
  localparam int ProdW     = 65;
  localparam int QuotW     = 65;

  localparam logic [31:0] OneQ30   = 32'h4000_0000;
  localparam logic [32:0] LimitPart = 33'h1_0000_0000;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdEval = 1'b1;

  localparam logic [1:0] RegDegree = 2'd0;
  localparam logic [1:0] RegCount  = 2'd1;
  localparam logic [1:0] RegLow    = 2'd2;
  localparam logic [1:0] RegHigh   = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [3:0] knot_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  column;
    logic [30:0] basis_value;
    logic        last;
    logic        error;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;      // capture the input item
    logic write_knot;   // store a knot
    logic range_chk;    // clear cursor search
    logic scan_step;    // examine one extended knot
    logic fix_cursor;   // apply right-boundary fix, clear distance index
    logic dist_step;    // compute one distance pair
    logic rec_init;     // basis[0] = one, k = 1
    logic den_step;     // form denominator for (k, r)
    logic mul_step;     // register both products
    logic div_start;    // start both divisions
    logic acc_step;     // combine quotients into basis[r]
    logic row_end;      // basis[k] = saved, advance k
    logic emit_init;    // start emission
    logic emit_adv;     // advance emission index
    logic set_err;      // flag error result
  } bsb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_eval;
    logic out_range;
    logic scan_done;
    logic bad_cursor;
    logic dist_done;
    logic den_zero;
    logic div_busy;
    logic row_done;   // r reached k
    logic rec_done;   // k reached order
    logic emit_skip;  // current column negative
    logic emit_final; // current index is last of order
  } bsb_stat_t;

  function automatic logic [DistW-1:0] sx32(input logic [31:0] v);
    sx32 = {{(DistW-32){v[31]}}, v};
  endfunction

endpackage
`default_nettype wire

// ----- design/bsb_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsb_in_if / bsb_out_if / bsb_cfg_if
// Valid/ready channels of the B-spline basis evaluator.
// ----------------------------------------------------------------------------
interface bsb_in_if;
  logic              valid;
  logic              ready;
  bsb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsb_out_if;
  logic               valid;
  logic               ready;
  bsb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bsb_cfg_if;
  logic               valid;
  logic               ready;
  bsb_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/bspline_basis_evaluator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bspline_basis_evaluator
// Cox-de Boor B-spline basis evaluation with a knot store.
// Load item: stores one knot. Evaluate item: decode, cursor search over the
// extended knots, degree distance steps, degree*(degree+1)/2 division steps
// (two serial 65-bit restoring dividers in parallel), then result emission.
// One item at a time; reset restores the register defaults, knots undefined.
// ----------------------------------------------------------------------------
module bspline_basis_evaluator (
  input  wire logic clk,
  input  wire logic rst,
  bsb_in_if.sink    in_ch,
  bsb_out_if.source out_ch,
  bsb_cfg_if.sink   cfg
);
  import bsb_pkg::*;

  bsb_cmd_t  cmd;
  bsb_stat_t stat;
  logic      in_ready, out_valid;

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;
  assign cfg.ready = 1'b1;

  bsb_controller u_ctrl (
    .clk, .rst,
    .in_fire(in_ch.valid && in_ready),
    .in_ready,
    .out_valid,
    .out_ready(out_ch.ready),
    .cmd, .stat
  );

  bsb_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .in_item(in_ch.data),
    .cfg_we(cfg.valid),
    .cfg_item(cfg.data),
    .out_item(out_ch.data)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during emission");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.data.error) |-> out_ch.data.last)
    else $error("error item not last");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.data.error) |-> out_ch.data.basis_value == '0)
    else $error("error item carries value");

endmodule
`default_nettype wire

// ----- design/bsb_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsb_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsb_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [bsb_pkg::ProdW-1:0]   dividend,
  input  wire logic [bsb_pkg::DistW-1:0]   divisor,
  output logic                             busy,
  output logic [bsb_pkg::QuotW-1:0]        quotient
);
  import bsb_pkg::*;

  localparam int StepW = $clog2(QuotW + 1);

  logic [QuotW-1:0] quot;
  logic [DistW:0]   rem;
  logic [DistW-1:0] dsr;
  logic [StepW-1:0] steps;
  logic [DistW:0]   trial;
  logic [DistW:0]   shifted;

  always_comb begin
    shifted = {rem[DistW-1:0], quot[QuotW-1]};
    trial   = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      quot  <= dividend;
      rem   <= '0;
      dsr   <= divisor;
      steps <= StepW'(QuotW);
    end else if (steps != '0) begin
      if (!trial[DistW]) begin
        rem  <= trial;
        quot <= {quot[QuotW-2:0], 1'b1};
      end else begin
        rem  <= shifted;
        quot <= {quot[QuotW-2:0], 1'b0};
      end
      steps <= steps - 1'b1;
    end
  end

  assign busy     = (steps != '0);
  assign quotient = quot;

endmodule
`default_nettype wire

// ----- design/bsb_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsb_datapath
// Knot store, cursor search, distances, Cox-de Boor recursion and emission.
// ----------------------------------------------------------------------------
module bsb_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire bsb_pkg::bsb_cmd_t    cmd,
  output bsb_pkg::bsb_stat_t        stat,
  input  wire bsb_pkg::in_item_t    in_item,
  input  wire logic                 cfg_we,
  input  wire bsb_pkg::cfg_item_t   cfg_item,
  output bsb_pkg::out_item_t        out_item
);
  import bsb_pkg::*;

  logic [DegW-1:0]    degree_reg;
  logic [CntW-1:0]    count_reg;
  logic signed [31:0] blow;
  logic signed [31:0] bhigh;

  logic signed [31:0] knots [MaxKnots];
  logic signed [31:0] knot_rd;

  in_item_t           item;
  logic [DegW-1:0]    deg;
  logic [3:0]         ord;
  logic [CntW-1:0]    nk;
  logic [ExtW-1:0]    size;
  logic [ExtW-1:0]    legit;

  logic [ExtW-1:0]    scan;
  logic signed [ExtW:0] curs;
  logic               found;
  logic signed [31:0] ext_k;
  logic signed [31:0] legit_val;

  logic [DistW-1:0]   rdist [MaxDegree];
  logic [DistW-1:0]   ldist [MaxDegree];
  logic [2:0]         di;
  logic [31:0]        basis [MaxDegree + 1];
  logic [3:0]         kk;
  logic [2:0]         rr;
  logic [DistW-1:0]   saved;
  logic [DistW-1:0]   rd_r, ld_r, den_r;
  logic               neg_r, neg_l;
  logic [ProdW-1:0]   prod_r, prod_l;
  logic [QuotW-1:0]   q_r, q_l;
  logic               busy_r, busy_l;
  logic [3:0]         ei;
  logic               err;

  // interior knot store
  always_ff @(posedge clk) begin
    if (cmd.write_knot) knots[item.knot_index] <= item.value;
  end

  always_comb begin
    deg = (degree_reg == '0) ? DegW'(1) : degree_reg;
    nk  = (count_reg > CntW'(MaxKnots)) ? CntW'(MaxKnots) : count_reg;
    ord = {1'b0, deg} + 4'd1;
    size  = ExtW'({ord, 1'b0}) + ExtW'(nk);
    legit = ExtW'(ord) + ExtW'(nk);
  end

  function automatic logic signed [31:0] ext_at(input logic [ExtW-1:0] i,
      input logic [3:0] o, input logic [CntW-1:0] n, input logic signed [31:0] lo,
      input logic signed [31:0] hi, input logic signed [31:0] kv);
    if (i < ExtW'(o)) ext_at = lo;
    else if (i < ExtW'(o) + ExtW'(n)) ext_at = kv;
    else ext_at = hi;
  endfunction

  logic [ExtW-1:0] ext_idx;
  logic [ExtW-1:0] kidx;
  always_comb begin
    if (cmd.scan_step || cmd.range_chk) ext_idx = scan;
    else if (cmd.fix_cursor) ext_idx = legit;
    else ext_idx = '0;
    kidx    = ext_idx - ExtW'(ord);
    knot_rd = knots[kidx[KnotW-1:0]];
    ext_k   = ext_at(ext_idx, ord, nk, blow, bhigh, knot_rd);
  end

  // distance knot read
  logic signed [ExtW:0]  dpos_r, dpos_l;
  logic [ExtW-1:0]       kr_i, kl_i;
  logic signed [31:0]    ext_r, ext_l;
  always_comb begin
    dpos_r = curs + (ExtW+1)'(di);
    dpos_l = curs - (ExtW+1)'(di) - 1'b1;
    kr_i = dpos_r[ExtW-1:0] - ExtW'(ord);
    kl_i = dpos_l[ExtW-1:0] - ExtW'(ord);
    ext_r = ext_at(dpos_r[ExtW-1:0], ord, nk, blow, bhigh, knots[kr_i[KnotW-1:0]]);
    ext_l = ext_at(dpos_l[ExtW-1:0], ord, nk, blow, bhigh, knots[kl_i[KnotW-1:0]]);
  end

  logic [2:0] lidx;
  logic [DistW-1:0] rd_c, ld_c, den_c;
  always_comb begin
    lidx  = 3'(kk - 4'd1 - {1'b0, rr});
    rd_c  = rdist[rr];
    ld_c  = ldist[lidx];
    den_c = rd_c + ld_c;
  end

  logic [DistW-1:0] mag_r, mag_l, mag_d;
  always_comb begin
    mag_r = rd_r[DistW-1] ? -rd_r : rd_r;
    mag_l = ld_r[DistW-1] ? -ld_r : ld_r;
    mag_d = den_r[DistW-1] ? -den_r : den_r;
  end

  bsb_divider u_div_r (.clk, .rst, .start(cmd.div_start), .dividend(prod_r),
                       .divisor(mag_d), .busy(busy_r), .quotient(q_r));
  bsb_divider u_div_l (.clk, .rst, .start(cmd.div_start), .dividend(prod_l),
                       .divisor(mag_d), .busy(busy_l), .quotient(q_l));

  logic [DistW-1:0] part_r, part_l, lim_r, lim_l;
  logic [DistW:0]   sum_c;
  always_comb begin
    lim_r = (q_r > QuotW'(LimitPart)) ? DistW'(LimitPart) : DistW'(q_r);
    lim_l = (q_l > QuotW'(LimitPart)) ? DistW'(LimitPart) : DistW'(q_l);
    part_r = neg_r ? -lim_r : lim_r;
    part_l = neg_l ? -lim_l : lim_l;
    sum_c  = {saved[DistW-1], saved} + {part_r[DistW-1], part_r};
  end

  function automatic logic [31:0] sat(input logic [DistW:0] v);
    if (v[DistW]) sat = '0;
    else if (v > (DistW+1)'(OneQ30)) sat = OneQ30;
    else sat = v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_reg <= 3'd3;
      count_reg  <= '0;
      blow       <= '0;
      bhigh      <= 32'sd65536;
      err        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_item.index)
          {1'b0, RegDegree}: degree_reg <= cfg_item.data[DegW-1:0];
          {1'b0, RegCount}:  count_reg  <= cfg_item.data[CntW-1:0];
          {1'b0, RegLow}:    blow       <= cfg_item.data;
          {1'b0, RegHigh}:   bhigh      <= cfg_item.data;
          default: ;
        endcase
      end
      if (cmd.load_in) err <= 1'b0;
      if (cmd.set_err) err <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) item <= in_item;
    if (cmd.range_chk) begin
      scan  <= '0;
      curs  <= '1;
      found <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (ext_k >= item.value) curs <= (ExtW+1)'(scan);
      if (ext_k > item.value) found <= 1'b1;
      scan <= scan + 1'b1;
    end
    if (cmd.fix_cursor) begin
      if (curs > $signed({1'b0, legit}) && item.value == ext_k)
        curs <= $signed({1'b0, legit});
      di <= '0;
    end
    if (cmd.dist_step) begin
      rdist[di] <= sx32(ext_r) - sx32(item.value);
      ldist[di] <= sx32(item.value) - sx32(ext_l);
      di <= di + 1'b1;
    end
    if (cmd.rec_init) begin
      basis[0] <= OneQ30;
      kk <= 4'd1;
      rr <= '0;
      saved <= '0;
    end
    if (cmd.den_step) begin
      rd_r  <= rd_c;
      ld_r  <= ld_c;
      den_r <= den_c;
    end
    if (cmd.mul_step) begin
      prod_r <= ProdW'(basis[rr]) * ProdW'(mag_r);
      prod_l <= ProdW'(basis[rr]) * ProdW'(mag_l);
      neg_r  <= rd_r[DistW-1] ^ den_r[DistW-1];
      neg_l  <= ld_r[DistW-1] ^ den_r[DistW-1];
    end
    if (cmd.acc_step) begin
      basis[rr] <= sat(sum_c);
      saved <= part_l;
      rr <= rr + 1'b1;
    end
    if (cmd.row_end) begin
      basis[kk[2:0]] <= sat({saved[DistW-1], saved});
      saved <= '0;
      kk <= kk + 1'b1;
      rr <= '0;
    end
    if (cmd.emit_init) ei <= '0;
    if (cmd.emit_adv)  ei <= ei + 1'b1;
  end

  logic signed [ExtW+1:0] colv;
  logic signed [ExtW:0]   deg_s;
  always_comb begin
    deg_s = $signed((ExtW+1)'(deg));
    colv = (ExtW+2)'(curs) - (ExtW+2)'(ord) - (ExtW+2)'(1) + (ExtW+2)'(ei);
    stat.is_eval    = item.cmd == CmdEval;
    stat.out_range  = item.value < blow || item.value > bhigh;
    stat.scan_done  = found || scan == size;
    stat.bad_cursor = (curs < deg_s) || (curs + deg_s > $signed({1'b0, size}));
    stat.dist_done  = di == deg;
    stat.den_zero   = den_c == '0;
    stat.div_busy   = busy_r | busy_l;
    stat.row_done   = {1'b0, rr} == kk;
    stat.rec_done   = kk == ord;
    stat.emit_skip  = colv < 0;
    stat.emit_final = ei == ord - 4'd1;
    out_item.column      = err ? '0 : colv[4:0];
    out_item.basis_value = err ? '0 : basis[ei[2:0]][30:0];
    out_item.last        = err ? 1'b1 : (ei == ord - 4'd1);
    out_item.error       = err;
  end

endmodule
`default_nettype wire

// ----- design/bsb_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsb_controller
// Sequencer for load, search, recursion and result emission.
// ----------------------------------------------------------------------------
module bsb_controller (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_fire,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bsb_pkg::bsb_cmd_t       cmd,
  input  wire bsb_pkg::bsb_stat_t stat
);
  import bsb_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_DEC   = 13'b0000000000010,
    S_SCAN  = 13'b0000000000100,
    S_FIX   = 13'b0000000001000,
    S_CHK   = 13'b0000000010000,
    S_DIST  = 13'b0000000100000,
    S_DEN   = 13'b0000001000000,
    S_MUL   = 13'b0000010000000,
    S_DIV   = 13'b0000100000000,
    S_WAIT  = 13'b0001000000000,
    S_ACC   = 13'b0010000000000,
    S_EMIT  = 13'b0100000000000,
    S_ERR   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_in = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat.is_eval) begin
          cmd.write_knot = 1'b1;
          state_next = S_IDLE;
        end else if (stat.out_range) begin
          cmd.set_err = 1'b1;
          state_next = S_ERR;
        end else begin
          cmd.range_chk = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_FIX;
        else cmd.scan_step = 1'b1;
      end
      S_FIX: begin
        cmd.fix_cursor = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.bad_cursor) begin
          cmd.set_err = 1'b1;
          state_next = S_ERR;
        end else state_next = S_DIST;
      end
      S_DIST: begin
        if (stat.dist_done) begin
          cmd.rec_init = 1'b1;
          state_next = S_DEN;
        end else cmd.dist_step = 1'b1;
      end
      S_DEN: begin
        if (stat.rec_done) begin
          cmd.emit_init = 1'b1;
          state_next = S_EMIT;
        end else if (stat.row_done) begin
          cmd.row_end = 1'b1;
        end else if (stat.den_zero) begin
          cmd.set_err = 1'b1;
          state_next = S_ERR;
        end else begin
          cmd.den_step = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!stat.div_busy) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        state_next = S_DEN;
      end
      S_EMIT: begin
        if (stat.emit_skip) begin
          cmd.emit_adv = 1'b1;
        end else begin
          out_valid = 1'b1;
          if (out_ready) begin
            cmd.emit_adv = 1'b1;
            if (stat.emit_final) state_next = S_IDLE;
          end
        end
      end
      S_ERR: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule
`default_nettype wire
